FILE: sv/qri_pkg.sv
// Shared types, constants and saturating arithmetic for the quadrupole-rate integrand.
package qri_pkg;

  localparam int WORD_BITS = 32;
  localparam int CFG_BITS  = 31;
  localparam int IDX_BITS  = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_RADIUS = 2'd1,
    MODE_ENERGY = 2'd2,
    MODE_FLOOR  = 2'd3
  } mode_e;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_MODE          = 2'd0,
    CFG_CUT_RADIUS    = 2'd1,
    CFG_DENSITY_FLOOR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    mode_e               mode;
    logic [CFG_BITS-1:0] cut_radius;
    logic [CFG_BITS-1:0] density_floor;
  } cfg_t;

  typedef struct packed {
    word_t density;
    word_t volume_factor;
    word_t lorentz_factor;
    word_t pressure;
    word_t specific_energy;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
  } in_item_t;

  typedef struct packed {
    word_t rate_xx;
    word_t rate_xy;
    word_t rate_xz;
    word_t rate_yy;
    word_t rate_yz;
    word_t rate_zz;
  } out_item_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic word_t sat_fit(logic [WORD_BITS:0] s);
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    return sat_fit({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    return sat_fit({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
  endfunction

  function automatic word_t sat_const(logic [63:0] v);
    if (v > {{(64-WORD_BITS){1'b0}}, WORD_MAX}) begin
      return WORD_MAX;
    end
    return word_t'(v[WORD_BITS-1:0]);
  endfunction

endpackage

FILE: sv/qri_stream_if.sv
// Valid/ready stream interfaces for grid-point beats and integrand beats.
interface qri_in_if;
  logic               valid;
  logic               ready;
  qri_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qri_out_if;
  logic               valid;
  logic               ready;
  qri_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/qri_delay.sv
// Enabled shift-register delay line used to align operands between pipeline stages.
module qri_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

FILE: sv/qri_fmul.sv
// Two-stage fixed-point multiplier with round-half-away rounding and saturation.
module qri_fmul #(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  qri_pkg::word_t a_i,
  input  qri_pkg::word_t b_i,
  output qri_pkg::word_t p_o
);

  localparam int W  = qri_pkg::WORD_BITS;
  localparam int PW = 2 * W;
  localparam logic [PW:0] ROUND_BIT = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [PW:0] LIM_NEG   = {{PW{1'b0}}, 1'b1} << (W - 1);
  localparam logic [PW:0] LIM_POS   = LIM_NEG - {{PW{1'b0}}, 1'b1};

  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [PW:0]   rnd;
  logic [PW:0]   quo;
  logic [PW:0]   lim;
  logic [W-1:0]  mag_p;
  qri_pkg::word_t p_d;
  qri_pkg::word_t p_q;

  assign mag_a = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= mag_a * mag_b;
      neg_q  <= a_i[W-1] ^ b_i[W-1];
    end
  end

  always_comb begin
    rnd   = {1'b0, prod_q} + ROUND_BIT;
    quo   = rnd >> FRAC_BITS;
    lim   = neg_q ? LIM_NEG : LIM_POS;
    mag_p = (quo > lim) ? lim[W-1:0] : quo[W-1:0];
    p_d   = neg_q ? qri_pkg::word_t'(~mag_p + 1'b1) : qri_pkg::word_t'(mag_p);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: sv/qri_weight.sv
// Weight pipeline: mass or energy-density weight and the radius or density-floor cut.
module qri_weight #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  qri_pkg::cfg_t     cfg_i,
  input  qri_pkg::in_item_t item_i,
  output qri_pkg::word_t    weight_o
);

  localparam int W  = qri_pkg::WORD_BITS;
  localparam int PW = 2 * W;
  localparam int RW = 2 * qri_pkg::CFG_BITS;
  localparam qri_pkg::word_t ONE = qri_pkg::sat_const(64'd1 << FRAC_BITS);

  qri_pkg::word_t rho1, vol9, lor2, lor4, lor6, prs3, prs8;
  qri_pkg::word_t rv, w0, w0_11, m1, m2, m3, w2;
  qri_pkg::word_t t1_q, rh_q, s_q;
  logic           zero3, floor_q, floor3, cut3, cut11;
  logic [W-1:0]   mag_x, mag_y, mag_z;
  logic [PW-1:0]  sqx_q, sqy_q, sqz_q;
  logic [PW+1:0]  sum_q;
  logic [RW-1:0]  r2_q;
  logic           rad_cut_q;

  // Stage 1: one plus specific energy, squared coordinates and density-floor test.
  assign mag_x = item_i.pos_x[W-1] ? (~item_i.pos_x + 1'b1) : item_i.pos_x;
  assign mag_y = item_i.pos_y[W-1] ? (~item_i.pos_y + 1'b1) : item_i.pos_y;
  assign mag_z = item_i.pos_z[W-1] ? (~item_i.pos_z + 1'b1) : item_i.pos_z;

  always_ff @(posedge clk_i) begin
    r2_q <= {{qri_pkg::CFG_BITS{1'b0}}, cfg_i.cut_radius} *
            {{qri_pkg::CFG_BITS{1'b0}}, cfg_i.cut_radius};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q      <= qri_pkg::sat_add(ONE, item_i.specific_energy);
      floor_q   <= $signed(item_i.density) <= $signed({1'b0, cfg_i.density_floor});
      sqx_q     <= mag_x * mag_x;
      sqy_q     <= mag_y * mag_y;
      sqz_q     <= mag_z * mag_z;
      sum_q     <= {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
      rad_cut_q <= sum_q >= {{(PW+2-RW){1'b0}}, r2_q};
    end
  end

  qri_delay #(.WIDTH(W), .DEPTH(1)) u_rho1 (.clk_i, .en_i, .d_i(item_i.density), .q_o(rho1));
  qri_delay #(.WIDTH(W), .DEPTH(9)) u_vol9 (
    .clk_i, .en_i, .d_i(item_i.volume_factor), .q_o(vol9));
  qri_delay #(.WIDTH(W), .DEPTH(2)) u_lor2 (
    .clk_i, .en_i, .d_i(item_i.lorentz_factor), .q_o(lor2));
  qri_delay #(.WIDTH(W), .DEPTH(2)) u_lor4 (.clk_i, .en_i, .d_i(lor2), .q_o(lor4));
  qri_delay #(.WIDTH(W), .DEPTH(2)) u_lor6 (.clk_i, .en_i, .d_i(lor4), .q_o(lor6));
  qri_delay #(.WIDTH(W), .DEPTH(3)) u_prs3 (.clk_i, .en_i, .d_i(item_i.pressure), .q_o(prs3));
  qri_delay #(.WIDTH(W), .DEPTH(5)) u_prs8 (.clk_i, .en_i, .d_i(prs3), .q_o(prs8));
  qri_delay #(.WIDTH(1), .DEPTH(3)) u_zero3 (
    .clk_i, .en_i, .d_i(item_i.density == '0), .q_o(zero3));
  qri_delay #(.WIDTH(1), .DEPTH(2)) u_floor3 (.clk_i, .en_i, .d_i(floor_q), .q_o(floor3));

  // Mass weight: density times volume factor times Lorentz factor.
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_rv (
    .clk_i, .en_i, .a_i(item_i.density), .b_i(item_i.volume_factor), .p_o(rv));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_w0 (.clk_i, .en_i, .a_i(rv), .b_i(lor2), .p_o(w0));
  qri_delay #(.WIDTH(W), .DEPTH(7)) u_w0_11 (.clk_i, .en_i, .d_i(w0), .q_o(w0_11));

  // Energy-density weight: volume factor times (rho h W^2 - pressure).
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clk_i, .en_i, .a_i(rho1), .b_i(t1_q), .p_o(m1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rh_q <= zero3 ? '0 : qri_pkg::sat_add(m1, prs3);
      s_q  <= qri_pkg::sat_sub(m3, prs8);
    end
  end

  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clk_i, .en_i, .a_i(rh_q), .b_i(lor4), .p_o(m2));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clk_i, .en_i, .a_i(m2), .b_i(lor6), .p_o(m3));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_w2 (.clk_i, .en_i, .a_i(vol9), .b_i(s_q), .p_o(w2));

  always_comb begin
    case (cfg_i.mode)
      qri_pkg::MODE_RADIUS: cut3 = rad_cut_q;
      qri_pkg::MODE_ENERGY: cut3 = rad_cut_q;
      qri_pkg::MODE_FLOOR:  cut3 = floor3;
      default:              cut3 = 1'b0;
    endcase
  end

  qri_delay #(.WIDTH(1), .DEPTH(8)) u_cut11 (.clk_i, .en_i, .d_i(cut3), .q_o(cut11));

  assign weight_o = cut11 ? '0 : ((cfg_i.mode == qri_pkg::MODE_ENERGY) ? w2 : w0_11);

endmodule

FILE: sv/qri_moment.sv
// Velocity-position moment pipeline: trace-free diagonal and symmetric off-diagonal factors.
module qri_moment #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  qri_pkg::in_item_t  item_i,
  output qri_pkg::out_item_t factor_o
);

  localparam int W = qri_pkg::WORD_BITS;
  localparam qri_pkg::word_t TWO_THIRDS =
    qri_pkg::sat_const(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);

  qri_pkg::word_t dxx, dyy, dzz, dxy, dyx, dxz, dzx, dyz, dzy;
  qri_pkg::word_t s1_q, s2_q, oxy_q, oxz_q, oyz_q, dzz3, mar;
  qri_pkg::word_t exx_q, eyy_q, ezz_q;
  qri_pkg::word_t dxx6, dyy6, dzz6;
  qri_pkg::word_t exx11, eyy11, ezz11, oxy11, oxz11, oyz11;

  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_xx (
    .clk_i, .en_i, .a_i(item_i.vel_x), .b_i(item_i.pos_x), .p_o(dxx));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_yy (
    .clk_i, .en_i, .a_i(item_i.vel_y), .b_i(item_i.pos_y), .p_o(dyy));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_zz (
    .clk_i, .en_i, .a_i(item_i.vel_z), .b_i(item_i.pos_z), .p_o(dzz));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_xy (
    .clk_i, .en_i, .a_i(item_i.vel_x), .b_i(item_i.pos_y), .p_o(dxy));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_yx (
    .clk_i, .en_i, .a_i(item_i.vel_y), .b_i(item_i.pos_x), .p_o(dyx));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_xz (
    .clk_i, .en_i, .a_i(item_i.vel_x), .b_i(item_i.pos_z), .p_o(dxz));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_zx (
    .clk_i, .en_i, .a_i(item_i.vel_z), .b_i(item_i.pos_x), .p_o(dzx));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_yz (
    .clk_i, .en_i, .a_i(item_i.vel_y), .b_i(item_i.pos_z), .p_o(dyz));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_zy (
    .clk_i, .en_i, .a_i(item_i.vel_z), .b_i(item_i.pos_y), .p_o(dzy));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= qri_pkg::sat_add(dxx, dyy);
      oxy_q <= qri_pkg::sat_add(dxy, dyx);
      oxz_q <= qri_pkg::sat_add(dxz, dzx);
      oyz_q <= qri_pkg::sat_add(dyz, dzy);
      s2_q  <= qri_pkg::sat_add(s1_q, dzz3);
      exx_q <= qri_pkg::sat_sub(qri_pkg::sat_add(dxx6, dxx6), mar);
      eyy_q <= qri_pkg::sat_sub(qri_pkg::sat_add(dyy6, dyy6), mar);
      ezz_q <= qri_pkg::sat_sub(qri_pkg::sat_add(dzz6, dzz6), mar);
    end
  end

  qri_delay #(.WIDTH(W), .DEPTH(1)) u_dzz3 (.clk_i, .en_i, .d_i(dzz), .q_o(dzz3));
  qri_delay #(.WIDTH(3*W), .DEPTH(4)) u_diag6 (
    .clk_i, .en_i, .d_i({dxx, dyy, dzz}), .q_o({dxx6, dyy6, dzz6}));

  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_mar (
    .clk_i, .en_i, .a_i(TWO_THIRDS), .b_i(s2_q), .p_o(mar));

  qri_delay #(.WIDTH(3*W), .DEPTH(4)) u_diag11 (
    .clk_i, .en_i, .d_i({exx_q, eyy_q, ezz_q}), .q_o({exx11, eyy11, ezz11}));
  qri_delay #(.WIDTH(3*W), .DEPTH(8)) u_off11 (
    .clk_i, .en_i, .d_i({oxy_q, oxz_q, oyz_q}), .q_o({oxy11, oxz11, oyz11}));

  assign factor_o.rate_xx = exx11;
  assign factor_o.rate_xy = oxy11;
  assign factor_o.rate_xz = oxz11;
  assign factor_o.rate_yy = eyy11;
  assign factor_o.rate_yz = oyz11;
  assign factor_o.rate_zz = ezz11;

endmodule

FILE: sv/quadrupole_rate_integrand.sv
// Top level of the quadrupole-rate integrand pipeline with its configuration registers.
//
// Each beat on in_i carries one grid point's fluid values; each beat on out_o carries
// the six integrand components for that point, in the same order as accepted.
// Both channels move a beat at a rising edge where valid and ready are high.
// The pipeline has fourteen register stages, the longest path being the energy-density
// weight chain of four two-stage multipliers followed by the final weight multiply.
// A new point can be taken every cycle while the receiver keeps out_o.ready high,
// so the sustained rate is one beat per cycle.
// When the receiver holds ready low with a result waiting, the whole pipeline freezes
// and in_i.ready drops in the same cycle; nothing is dropped or duplicated.
// The configuration port writes mode, outer radius and density floor through
// cfg_we_i, cfg_idx_i and cfg_data_i; writes belong to times when no beat is in flight.
// Reset clears all valid bits and sets mode to plain, outer radius to its maximum
// and the density floor to zero.
module quadrupole_rate_integrand #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  qri_in_if.sink                              in_i,
  qri_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [qri_pkg::IDX_BITS-1:0]        cfg_idx_i,
  input  logic [qri_pkg::CFG_BITS-1:0]        cfg_data_i
);

  localparam int STAGES = 14;

  logic               adv;
  logic [STAGES-1:0]  v_q;
  qri_pkg::cfg_t      cfg_q;
  qri_pkg::in_item_t  in_q;
  qri_pkg::word_t     weight;
  qri_pkg::out_item_t factor;

  assign adv        = !v_q[STAGES-1] || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[STAGES-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= qri_pkg::MODE_PLAIN;
      cfg_q.cut_radius    <= '1;
      cfg_q.density_floor <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qri_pkg::CFG_MODE:          cfg_q.mode <= qri_pkg::mode_e'(cfg_data_i[1:0]);
        qri_pkg::CFG_CUT_RADIUS:    cfg_q.cut_radius <= cfg_data_i;
        qri_pkg::CFG_DENSITY_FLOOR: cfg_q.density_floor <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_i.data;
    end
  end

  qri_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
    .clk_i, .en_i(adv), .cfg_i(cfg_q), .item_i(in_q), .weight_o(weight));

  qri_moment #(.FRAC_BITS(FRAC_BITS)) u_moment (
    .clk_i, .en_i(adv), .item_i(in_q), .factor_o(factor));

  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_out_xx (
    .clk_i, .en_i(adv), .a_i(weight), .b_i(factor.rate_xx), .p_o(out_o.data.rate_xx));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_out_xy (
    .clk_i, .en_i(adv), .a_i(weight), .b_i(factor.rate_xy), .p_o(out_o.data.rate_xy));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_out_xz (
    .clk_i, .en_i(adv), .a_i(weight), .b_i(factor.rate_xz), .p_o(out_o.data.rate_xz));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_out_yy (
    .clk_i, .en_i(adv), .a_i(weight), .b_i(factor.rate_yy), .p_o(out_o.data.rate_yy));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_out_yz (
    .clk_i, .en_i(adv), .a_i(weight), .b_i(factor.rate_yz), .p_o(out_o.data.rate_yz));
  qri_fmul #(.FRAC_BITS(FRAC_BITS)) u_out_zz (
    .clk_i, .en_i(adv), .a_i(weight), .b_i(factor.rate_zz), .p_o(out_o.data.rate_zz));

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("Accepted beat did not enter the first stage.");

  a_last_stage_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[STAGES-2] && adv |=> out_o.valid)
    else $error("Beat in the next-to-last stage was lost on its way out.");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("Waiting result changed while the receiver stalled.");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for quadrupole_rate_integrand: directed probes, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qri_pkg::*;

  localparam int        FRAC       = 24;
  localparam int        PIPE_DEPTH = 14;
  localparam int        PHASES     = 8;
  localparam int        PHASE_LEN  = 225;
  localparam word_t     ZERO       = word_t'(0);
  localparam word_t     ONE        = word_t'(64'd1 << FRAC);
  localparam word_t     HALF       = word_t'(64'd1 << (FRAC - 1));
  localparam word_t     TWO_THIRDS = word_t'(((64'd2 << FRAC) + 64'd1) / 64'd3);
  localparam word_t     UNIT_XX    = 2 * ONE - TWO_THIRDS;
  localparam [30:0]     CFG_MAX    = 31'h7FFF_FFFF;
  localparam longint    SPAN_HI    = 64'sd2147483647;
  localparam longint    SPAN_LO    = -64'sd2147483648;

  typedef struct {
    mode_e     mode;
    logic [30:0] radius;
    logic [30:0] floor_lvl;
    in_item_t  pt;
    bit        typed;
    out_item_t want;
  } probe_t;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;

  qri_in_if  in_ch ();
  qri_out_if out_ch ();

  quadrupole_rate_integrand u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mode_e       cur_mode;
  logic [30:0] cur_radius;
  logic [30:0] cur_floor;
  out_item_t   pending_rates[$];
  probe_t      probes[$];
  int          errors;
  int          beat_no;
  bit          steady;
  string       field_name[6] = '{"rate_xx", "rate_xy", "rate_xz", "rate_yy", "rate_yz",
                                 "rate_zz"};

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("quadrupole_rate_integrand verification failed");
    $finish;
  end

  function automatic word_t clamp_word(longint v);
    if (v > SPAN_HI) begin
      return word_t'(SPAN_HI);
    end
    if (v < SPAN_LO) begin
      return word_t'(SPAN_LO);
    end
    return word_t'(v);
  endfunction

  function automatic word_t add_sat(word_t a, word_t b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  function automatic word_t sub_sat(word_t a, word_t b);
    return clamp_word(longint'(a) - longint'(b));
  endfunction

  function automatic logic [63:0] mag(word_t a);
    return a[31] ? 64'(-longint'(a)) : 64'(longint'(a));
  endfunction

  function automatic word_t fx_mul(word_t a, word_t b);
    logic        neg;
    logic [63:0] q;
    logic [63:0] lim;
    neg = a[31] ^ b[31];
    q   = (mag(a) * mag(b) + (64'd1 << (FRAC - 1))) >> FRAC;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
    end
    if (q == 64'd0) begin
      return ZERO;
    end
    return neg ? word_t'(-q) : word_t'(q);
  endfunction

  function automatic logic beyond_radius(word_t x, word_t y, word_t z, logic [30:0] r);
    logic [65:0] s;
    logic [65:0] r2;
    s  = 66'(mag(x) * mag(x)) + 66'(mag(y) * mag(y)) + 66'(mag(z) * mag(z));
    r2 = 66'(r) * 66'(r);
    return s >= r2;
  endfunction

  function automatic out_item_t integrand(in_item_t p);
    logic      cut;
    word_t     w, rh, mar;
    word_t     dxx, dyy, dzz, dxy, dyx, dxz, dzx, dyz, dzy;
    out_item_t r;
    cut = 1'b0;
    case (cur_mode)
      MODE_RADIUS, MODE_ENERGY: cut = beyond_radius(p.pos_x, p.pos_y, p.pos_z, cur_radius);
      MODE_FLOOR:               cut = longint'(p.density) <= longint'(cur_floor);
      default:                  cut = 1'b0;
    endcase
    if (cut) begin
      w = ZERO;
    end else if (cur_mode == MODE_ENERGY) begin
      rh = ZERO;
      if (p.density != ZERO) begin
        rh = add_sat(fx_mul(p.density, add_sat(ONE, p.specific_energy)), p.pressure);
      end
      w = fx_mul(p.volume_factor,
                 sub_sat(fx_mul(fx_mul(rh, p.lorentz_factor), p.lorentz_factor), p.pressure));
    end else begin
      w = fx_mul(fx_mul(p.density, p.volume_factor), p.lorentz_factor);
    end
    dxx = fx_mul(p.vel_x, p.pos_x);
    dyy = fx_mul(p.vel_y, p.pos_y);
    dzz = fx_mul(p.vel_z, p.pos_z);
    dxy = fx_mul(p.vel_x, p.pos_y);
    dyx = fx_mul(p.vel_y, p.pos_x);
    dxz = fx_mul(p.vel_x, p.pos_z);
    dzx = fx_mul(p.vel_z, p.pos_x);
    dyz = fx_mul(p.vel_y, p.pos_z);
    dzy = fx_mul(p.vel_z, p.pos_y);
    mar = fx_mul(TWO_THIRDS, add_sat(add_sat(dxx, dyy), dzz));
    r.rate_xx = fx_mul(w, sub_sat(add_sat(dxx, dxx), mar));
    r.rate_xy = fx_mul(w, add_sat(dxy, dyx));
    r.rate_xz = fx_mul(w, add_sat(dxz, dzx));
    r.rate_yy = fx_mul(w, sub_sat(add_sat(dyy, dyy), mar));
    r.rate_yz = fx_mul(w, add_sat(dyz, dzy));
    r.rate_zz = fx_mul(w, sub_sat(add_sat(dzz, dzz), mar));
    return r;
  endfunction

  function automatic in_item_t grid_point(word_t rho, word_t vol, word_t lor, word_t prs,
                                          word_t eps, word_t vx, word_t vy, word_t vz,
                                          word_t px, word_t py, word_t pz);
    in_item_t p;
    p.density         = rho;
    p.volume_factor   = vol;
    p.lorentz_factor  = lor;
    p.pressure        = prs;
    p.specific_energy = eps;
    p.vel_x           = vx;
    p.vel_y           = vy;
    p.vel_z           = vz;
    p.pos_x           = px;
    p.pos_y           = py;
    p.pos_z           = pz;
    return p;
  endfunction

  function automatic void add_probe(mode_e m, logic [30:0] r, logic [30:0] f, in_item_t p,
                                    bit typed, out_item_t want);
    probe_t pr;
    pr.mode      = m;
    pr.radius    = r;
    pr.floor_lvl = f;
    pr.pt        = p;
    pr.typed     = typed;
    pr.want      = want;
    probes.push_back(pr);
  endfunction

  function automatic word_t rand_word();
    word_t m;
    case ($urandom_range(0, 9))
      0: return word_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return ZERO;
          3:       return word_t'(1);
          default: return word_t'(-1);
        endcase
      end
      default: begin
        m = word_t'($urandom_range(0, 1 << (20 + $urandom_range(0, 5))));
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  function automatic in_item_t random_point();
    in_item_t p;
    p = grid_point(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word());
    case ($urandom_range(0, 9))
      0:       p.density = ZERO;
      1:       p.density = word_t'(cur_floor) + word_t'($urandom_range(0, 2)) - word_t'(1);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      p.pos_x = word_t'(cur_radius) + word_t'($urandom_range(0, 2)) - word_t'(1);
      p.pos_y = ZERO;
      p.pos_z = ZERO;
    end
    return p;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 35);
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= 100) begin
      $display("MISMATCH: %s", what);
    end
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t   want;
    logic [31:0] g, e;
    if (pending_rates.size() == 0) begin
      flag_mismatch($sformatf("beat %0d arrived with nothing outstanding", beat_no));
      beat_no++;
      return;
    end
    want = pending_rates.pop_front();
    for (int k = 0; k < 6; k++) begin
      g = got[32*(5-k) +: 32];
      e = want[32*(5-k) +: 32];
      if (g !== e) begin
        flag_mismatch($sformatf("beat %0d %s got %h want %h", beat_no, field_name[k], g, e));
      end
    end
    beat_no++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      check_beat(out_ch.data);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !take_break();
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:          cur_mode   = mode_e'(val[1:0]);
      CFG_CUT_RADIUS:    cur_radius = val;
      CFG_DENSITY_FLOOR: cur_floor  = val;
      default:           ;
    endcase
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (pending_rates.size() == 0);
    repeat (PIPE_DEPTH) @(negedge clk_i);
  endtask

  task automatic send_point(in_item_t p, bit typed, out_item_t want);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_rates.push_back(typed ? want : integrand(p));
    @(negedge clk_i);
  endtask

  initial begin
    in_item_t    unit_pt;
    in_item_t    pt;
    out_item_t   unit_want;
    probe_t      pr;
    logic [30:0] radius;
    logic [30:0] floor_lvl;

    errors      = 0;
    beat_no     = 0;
    steady      = 1'b0;
    cur_mode    = MODE_PLAIN;
    cur_radius  = CFG_MAX;
    cur_floor   = '0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_MODE;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    unit_pt   = grid_point(ONE, ONE, ONE, ZERO, ZERO, ONE, ZERO, ZERO, ONE, ZERO, ZERO);
    unit_want = out_item_t'{UNIT_XX, ZERO, ZERO, -TWO_THIRDS, ZERO, -TWO_THIRDS};

    add_probe(MODE_PLAIN, CFG_MAX, '0, '0, 1, '0);
    add_probe(MODE_PLAIN, CFG_MAX, '0, unit_pt, 1, unit_want);
    pt = unit_pt;
    pt.pressure        = WORD_MAX;
    pt.specific_energy = WORD_MIN;
    add_probe(MODE_PLAIN, CFG_MAX, '0, pt, 1, unit_want);
    add_probe(MODE_PLAIN, CFG_MAX, '0, {11{WORD_MAX}}, 0, '0);
    add_probe(MODE_PLAIN, CFG_MAX, '0, {11{WORD_MIN}}, 0, '0);
    add_probe(MODE_PLAIN, CFG_MAX, '0,
              grid_point(WORD_MAX, WORD_MIN, ONE, ZERO, ZERO, WORD_MIN, WORD_MAX, ONE,
                         WORD_MAX, WORD_MIN, -ONE), 0, '0);
    add_probe(MODE_PLAIN, CFG_MAX, '0,
              grid_point(HALF, ONE + HALF, ONE + 1, HALF, HALF, -HALF, ONE, HALF - 7,
                         2 * ONE, -3 * ONE, HALF + 99), 0, '0);
    add_probe(MODE_RADIUS, '0, '0, unit_pt, 1, '0);
    pt = unit_pt;
    pt.pos_x = 2 * ONE;
    add_probe(MODE_RADIUS, 31'(2 * ONE), '0, pt, 1, '0);
    pt.pos_x = 2 * ONE - 1;
    add_probe(MODE_RADIUS, 31'(2 * ONE), '0, pt, 0, '0);
    pt = unit_pt;
    pt.pos_x = WORD_MIN;
    pt.pos_y = WORD_MIN;
    pt.pos_z = WORD_MIN;
    add_probe(MODE_RADIUS, CFG_MAX, '0, pt, 1, '0);
    pt.pos_x = WORD_MAX;
    pt.pos_y = ZERO;
    pt.pos_z = ZERO;
    add_probe(MODE_RADIUS, CFG_MAX, '0, pt, 1, '0);
    pt = unit_pt;
    pt.density  = ZERO;
    pt.pressure = HALF;
    add_probe(MODE_ENERGY, CFG_MAX, '0, pt, 0, '0);
    add_probe(MODE_ENERGY, CFG_MAX, '0,
              grid_point(ONE, ONE + HALF, ONE + HALF, ONE >>> 2, HALF, HALF, -ONE, HALF,
                         ONE, HALF, -2 * ONE), 0, '0);
    add_probe(MODE_ENERGY, CFG_MAX, '0, {11{WORD_MAX}}, 0, '0);
    pt = unit_pt;
    pt.specific_energy = WORD_MAX;
    pt.pressure        = WORD_MIN;
    add_probe(MODE_ENERGY, CFG_MAX, '0, pt, 0, '0);
    pt = unit_pt;
    pt.pos_x = ZERO;
    pt.pos_y = ONE;
    pt.vel_y = ONE;
    add_probe(MODE_ENERGY, 31'(ONE), '0, pt, 1, '0);
    pt = unit_pt;
    pt.density = word_t'(-1);
    add_probe(MODE_FLOOR, CFG_MAX, '0, pt, 1, '0);
    pt.density = ZERO;
    add_probe(MODE_FLOOR, CFG_MAX, '0, pt, 1, '0);
    pt.density = WORD_MIN;
    add_probe(MODE_FLOOR, CFG_MAX, '0, pt, 1, '0);
    pt.density = word_t'(1);
    add_probe(MODE_FLOOR, CFG_MAX, '0, pt, 0, '0);
    add_probe(MODE_FLOOR, CFG_MAX, 31'(ONE), unit_pt, 1, '0);
    pt.density = ONE + 1;
    add_probe(MODE_FLOOR, CFG_MAX, 31'(ONE), pt, 0, '0);
    pt.density = WORD_MAX;
    add_probe(MODE_FLOOR, CFG_MAX, CFG_MAX, pt, 1, '0);

    foreach (probes[i]) begin
      pr = probes[i];
      if (pr.mode != cur_mode || pr.radius != cur_radius || pr.floor_lvl != cur_floor) begin
        settle();
        if (pr.mode != cur_mode) begin
          write_reg(CFG_MODE, 31'(pr.mode));
        end
        if (pr.radius != cur_radius) begin
          write_reg(CFG_CUT_RADIUS, pr.radius);
        end
        if (pr.floor_lvl != cur_floor) begin
          write_reg(CFG_DENSITY_FLOOR, pr.floor_lvl);
        end
      end
      send_point(pr.pt, pr.typed, pr.want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        radius = CFG_MAX;
      end else if (phase == 3) begin
        radius = '0;
      end else begin
        radius = 31'($urandom_range(1 << 22, 1 << 27));
      end
      if (phase == 6) begin
        floor_lvl = CFG_MAX;
      end else if (phase == 5) begin
        floor_lvl = '0;
      end else begin
        floor_lvl = 31'($urandom_range(0, 1 << 25));
      end
      write_reg(CFG_MODE, 31'((phase + 2) % 4));
      write_reg(CFG_CUT_RADIUS, radius);
      write_reg(CFG_DENSITY_FLOOR, floor_lvl);
      steady = (phase == 4);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_point(random_point(), 0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    steady = 1'b0;
    wait (pending_rates.size() == 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("quadrupole_rate_integrand verification clean");
    end else begin
      $display("quadrupole_rate_integrand verification failed");
    end
    $finish;
  end

endmodule
